### hdl/binary_heap_priority_queue_macros.svh
// Assertion macros shared by the heap queue modules.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset.
`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define BHPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define BHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BHPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define BHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/bhpq_pkg.sv
// Shared types, codes and command/status bundles of the heap queue.
package bhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [COUNT_W-1:0]      count_t;

  // Request operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Top key reported for an empty heap
  localparam key_t EMPTY_TOP = key_t'(-1);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic dispatch;
    logic ins_start;
    logic rem_start;
    logic rem_load;
    logic up_read;
    logic dn_read;
    logic place;
    logic move_up;
    logic move_down;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op_remove;
    logic full;
    logic empty;
    logic at_root;
    logic no_child;
    logic up_better;
    logic dn_better;
  } stat_t;

endpackage

### hdl/bhpq_in_if.sv
// Request channel: operation and key with valid/ready handshake.
interface bhpq_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  bhpq_pkg::key_t    key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

### hdl/bhpq_out_if.sv
// Result channel: top key, entry count and status with valid/ready handshake.
interface bhpq_out_if;
  logic                              valid;
  logic                              ready;
  bhpq_pkg::key_t                    top_key;
  bhpq_pkg::count_t                  entry_count;
  logic [bhpq_pkg::STATUS_W-1:0]     status;

  modport source (output valid, output top_key, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input top_key, input entry_count, input status,
                  output ready);
endinterface

### hdl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue.
//
//   Channel   Dir  Handshake        Payload
//   in_req    in   valid / ready    op, key
//   out_res   out  valid / ready    top_key, entry_count, status
//   cfg       in   cfg_we           cfg_wdata (order_max)
//
// One request at a time: between accept and result valid a request that changes the heap
// runs the sift loop, which steps through a read state and then a compare/write state
// per level on the single-write, two-read key store; requests are accepted only when idle.
// Synchronous active-low reset empties the heap and selects min order; the store
// itself is not cleared.
// A result waits in an output register; the next request is accepted and sifted
// meanwhile and stalls only at hand-off while the earlier result is still held.
module binary_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  bhpq_in_if.sink           in_req,
  bhpq_out_if.source        out_res,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  bhpq_pkg::cmd_t    cmd;
  bhpq_pkg::stat_t   stat;
  bhpq_pkg::key_t    res_top_key;
  bhpq_pkg::count_t  res_count;
  bhpq_pkg::status_t res_status;
  logic              in_ready;
  logic              out_valid;

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_req.op),
    .in_key      (in_req.key),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .res_top_key (res_top_key),
    .res_count   (res_count),
    .res_status  (res_status)
  );

  // Drive the channel ports
  assign in_req.ready        = in_ready;
  assign out_res.valid       = out_valid;
  assign out_res.top_key     = res_top_key;
  assign out_res.entry_count = res_count;
  assign out_res.status      = res_status;

endmodule

### hdl/bhpq_dp.sv
// Heap datapath: key store, sift registers, comparators and result register.
`include "binary_heap_priority_queue_macros.svh"
module bhpq_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bhpq_pkg::cmd_t      cmd,
  output bhpq_pkg::stat_t     stat,
  input  logic                in_op,
  input  bhpq_pkg::key_t      in_key,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  output bhpq_pkg::key_t      res_top_key,
  output bhpq_pkg::count_t    res_count,
  output bhpq_pkg::status_t   res_status
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + 2;
  localparam int WIDE_W = CNT_W + bhpq_pkg::COUNT_W;

  // Strict rank test in the selected order
  function automatic logic ranks_above(input bhpq_pkg::key_t a, input bhpq_pkg::key_t b,
                                       input logic order_max);
    ranks_above = order_max ? (a > b) : (a < b);
  endfunction

  bhpq_pkg::key_t    key_store_mem [CAPACITY];
  bhpq_pkg::key_t    rd_a_r, rd_b_r;
  bhpq_pkg::key_t    root_r, root_nxt;
  bhpq_pkg::key_t    cur_key_r, cur_key_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              op_r, op_nxt;
  logic              order_max_r, order_max_nxt;
  bhpq_pkg::status_t status_r, status_nxt;
  bhpq_pkg::key_t    res_top_r, res_top_nxt;
  bhpq_pkg::count_t  res_count_r, res_count_nxt;
  bhpq_pkg::status_t res_status_r, res_status_nxt;

  logic [IDX_W-1:0]  par_idx;
  logic [CH_W-1:0]   lc_idx, rc_idx, cnt_ext;
  logic              lc_ok, rc_ok;
  logic              best_l, best_r;
  bhpq_pkg::key_t    best_key, dn_val;
  logic [IDX_W-1:0]  dn_idx;
  logic              full, empty;
  logic              we, rd_en_a, rd_en_b;
  logic [IDX_W-1:0]  addr_a, addr_b;
  bhpq_pkg::key_t    wdata;
  logic [WIDE_W-1:0] cnt_wide;

  // Tree neighbours of the current position
  assign par_idx = (pos_r - IDX_W'(1)) >> 1;
  assign lc_idx  = CH_W'({pos_r, 1'b1});
  assign rc_idx  = lc_idx + CH_W'(1);
  assign cnt_ext = CH_W'(cnt_r);
  assign lc_ok   = lc_idx < cnt_ext;
  assign rc_ok   = rc_idx < cnt_ext;
  assign full    = cnt_r == CNT_W'(CAPACITY);
  assign empty   = cnt_r == '0;

  // Pick the best of the held key and its two children; ties go to the held key, then the left child
  assign best_l   = lc_ok && ranks_above(rd_a_r, cur_key_r, order_max_r);
  assign best_key = best_l ? rd_a_r : cur_key_r;
  assign best_r   = rc_ok && ranks_above(rd_b_r, best_key, order_max_r);
  assign dn_val   = best_r ? rd_b_r : rd_a_r;
  assign dn_idx   = best_r ? rc_idx[IDX_W-1:0] : lc_idx[IDX_W-1:0];

  // Status back to the controller
  assign stat.op_remove = op_r == bhpq_pkg::OP_REMOVE;
  assign stat.full      = full;
  assign stat.empty     = empty;
  assign stat.at_root   = pos_r == '0;
  assign stat.no_child  = !lc_ok;
  assign stat.up_better = ranks_above(cur_key_r, rd_a_r, order_max_r);
  assign stat.dn_better = best_l || best_r;

  // Memory port control
  assign we      = cmd.place || cmd.move_up || cmd.move_down;
  assign rd_en_a = cmd.rem_start || cmd.up_read || cmd.dn_read;
  assign rd_en_b = cmd.dn_read;
  assign addr_b  = rc_idx[IDX_W-1:0];

  always_comb begin
    if (cmd.rem_start) begin
      addr_a = IDX_W'(cnt_r - CNT_W'(1));
    end else if (cmd.up_read) begin
      addr_a = par_idx;
    end else begin
      addr_a = lc_idx[IDX_W-1:0];
    end
    if (cmd.place) begin
      wdata = cur_key_r;
    end else if (cmd.move_up) begin
      wdata = rd_a_r;
    end else begin
      wdata = dn_val;
    end
  end

  // Key store with one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      key_store_mem[pos_r] <= wdata;
    end
    if (rd_en_a) begin
      rd_a_r <= key_store_mem[addr_a];
    end
    if (rd_en_b) begin
      rd_b_r <= key_store_mem[addr_b];
    end
  end

  assign cnt_wide = WIDE_W'(cnt_r);

  // Next values of the sift and result registers
  always_comb begin
    cur_key_nxt    = cur_key_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    root_nxt       = root_r;
    order_max_nxt  = order_max_r;
    res_top_nxt    = res_top_r;
    res_count_nxt  = res_count_r;
    res_status_nxt = res_status_r;

    if (cfg_we) begin
      order_max_nxt = cfg_wdata;
    end
    if (cmd.accept) begin
      cur_key_nxt = in_key;
      op_nxt      = in_op;
    end
    if (cmd.dispatch) begin
      if (op_r == bhpq_pkg::OP_REMOVE && empty) begin
        status_nxt = bhpq_pkg::STAT_EMPTY;
      end else if (op_r == bhpq_pkg::OP_INSERT && full) begin
        status_nxt = bhpq_pkg::STAT_FULL;
      end else begin
        status_nxt = bhpq_pkg::STAT_DONE;
      end
    end
    if (cmd.ins_start) begin
      pos_nxt = IDX_W'(cnt_r);
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.rem_start) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (cmd.rem_load) begin
      cur_key_nxt = rd_a_r;
      pos_nxt     = '0;
    end
    if (cmd.move_up) begin
      pos_nxt = par_idx;
    end
    if (cmd.move_down) begin
      pos_nxt = dn_idx;
    end
    // Mirror the root entry
    if (we && pos_r == '0) begin
      root_nxt = wdata;
    end
    if (cmd.load_result) begin
      res_top_nxt    = empty ? bhpq_pkg::EMPTY_TOP : root_r;
      res_count_nxt  = cnt_wide[bhpq_pkg::COUNT_W-1:0];
      res_status_nxt = status_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      order_max_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      order_max_r <= order_max_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_key_r    <= cur_key_nxt;
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    status_r     <= status_nxt;
    root_r       <= root_nxt;
    res_top_r    <= res_top_nxt;
    res_count_r  <= res_count_nxt;
    res_status_r <= res_status_nxt;
  end

  assign res_top_key = res_top_r;
  assign res_count   = res_count_r;
  assign res_status  = res_status_r;

  `BHPQ_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(CAPACITY), "count above capacity")
  `BHPQ_ASSERT_NEXT(a_ins_grow, clk, rst_n, cmd.ins_start,
                    cnt_r == $past(cnt_r) + CNT_W'(1), "insert did not grow count")
  `BHPQ_ASSERT_NEXT(a_up_climbs, clk, rst_n, cmd.move_up,
                    pos_r < $past(pos_r), "sift-up did not climb")
  `BHPQ_ASSERT_NEXT(a_dn_sinks, clk, rst_n, cmd.move_down,
                    pos_r > $past(pos_r), "sift-down did not sink")

endmodule

### hdl/bhpq_ctrl.sv
// Heap controller: sequences dispatch, sift-up, sift-down and result hand-off.
`include "binary_heap_priority_queue_macros.svh"
module bhpq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bhpq_pkg::stat_t  stat,
  output bhpq_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_REM_LD   = 8'b0000_0100,
    S_UP_RD    = 8'b0000_1000,
    S_UP_CMP   = 8'b0001_0000,
    S_DN_RD    = 8'b0010_0000,
    S_DN_CMP   = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // Walk one request through its sift
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        if (stat.op_remove) begin
          if (stat.empty) begin
            state_nxt = S_FIN;
          end else begin
            cmd.rem_start = 1'b1;
            state_nxt     = S_REM_LD;
          end
        end else if (stat.full) begin
          state_nxt = S_FIN;
        end else begin
          cmd.ins_start = 1'b1;
          state_nxt     = S_UP_RD;
        end
      end
      S_REM_LD: begin
        if (stat.empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rem_load = 1'b1;
          state_nxt    = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.up_read = 1'b1;
          state_nxt   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_better) begin
          cmd.move_up = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DN_RD: begin
        if (stat.no_child) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.dn_read = 1'b1;
          state_nxt   = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_better) begin
          cmd.move_down = 1'b1;
          state_nxt     = S_DN_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until the sink takes it
  assign out_valid_nxt = cmd.load_result ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BHPQ_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_valid && in_ready,
                    state_r == S_DISPATCH, "accepted request not dispatched")
  `BHPQ_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.load_result,
                    !out_valid_r || out_ready, "waiting result overwritten")
  `BHPQ_ASSERT_SAME(a_valid_from_fin, clk, rst_n, $rose(out_valid_r),
                    $past(state_r == S_FIN), "result raised outside finish")

endmodule
